// ===== src/kaz_pkg.sv =====
package kaz_pkg;

  localparam int ValueW   = 16;
  localparam int StepW    = 10;
  localparam int HoldW    = 16;
  localparam int TimeW    = 32;
  localparam int KnobW    = 2;
  localparam int SlotW    = 2;
  localparam int MultW    = 3;
  localparam int ProdW    = StepW + 2;
  localparam int SumW     = ValueW + 2;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;
  localparam int NumTimer = 6;
  localparam int NumSlot  = 3;

  localparam logic [TimeW-1:0] ThreshSlow = 32'd75;
  localparam logic [TimeW-1:0] ThreshMid  = 32'd50;
  localparam logic [TimeW-1:0] ThreshFast = 32'd25;

  localparam logic signed [ValueW-1:0] OffsetZeroRst = 16'sd0;
  localparam logic signed [ValueW-1:0] LevelZeroRst  = 16'sd0;
  localparam logic [StepW-1:0]         StepSizeRst   = 10'd1;
  localparam logic [HoldW-1:0]         HoldTimeRst   = 16'd500;

  localparam logic [1:0] RegOffsetZero = 2'd0;
  localparam logic [1:0] RegLevelZero  = 2'd1;
  localparam logic [1:0] RegStepSize   = 2'd2;
  localparam logic [1:0] RegHoldTime   = 2'd3;

  localparam logic [KnobW-1:0] KnobChA    = 2'd0;
  localparam logic [KnobW-1:0] KnobChB    = 2'd1;
  localparam logic [KnobW-1:0] KnobTrig   = 2'd2;
  localparam logic [KnobW-1:0] KnobUnused = 2'd3;

  localparam logic [SlotW-1:0] SlotBad = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] offset_zero;
    logic signed [ValueW-1:0] level_zero;
    logic [StepW-1:0]         step_size;
    logic [HoldW-1:0]         hold_time_ms;
  } cfg_t;

endpackage

// ===== src/kaz_if.sv =====
interface kaz_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [kaz_pkg::KnobW-1:0]             knob;
  logic                                  direction;
  logic [kaz_pkg::SlotW-1:0]             trigger_source;
  logic signed [kaz_pkg::ValueW-1:0]     current_value;
  logic [kaz_pkg::TimeW-1:0]             now_ms;

  modport source (output valid, knob, direction, trigger_source, current_value, now_ms,
                  input ready);
  modport sink (input valid, knob, direction, trigger_source, current_value, now_ms,
                output ready);
endinterface

interface kaz_out_if;
  logic                              valid;
  logic                              ready;
  logic                              apply;
  logic signed [kaz_pkg::ValueW-1:0] new_value;
  logic [kaz_pkg::SlotW-1:0]         slot;

  modport source (output valid, apply, new_value, slot, input ready);
  modport sink (input valid, apply, new_value, slot, output ready);
endinterface

// ===== src/kaz_cfg.sv =====
module kaz_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kaz_pkg::AddrW-1:0]   paddr,
  input  logic [kaz_pkg::DataW-1:0]   pwdata,
  output logic [kaz_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output kaz_pkg::cfg_t               cfg
);

  kaz_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_zero  <= kaz_pkg::OffsetZeroRst;
      cfg_r.level_zero   <= kaz_pkg::LevelZeroRst;
      cfg_r.step_size    <= kaz_pkg::StepSizeRst;
      cfg_r.hold_time_ms <= kaz_pkg::HoldTimeRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        kaz_pkg::RegOffsetZero: cfg_r.offset_zero  <= pwdata[kaz_pkg::ValueW-1:0];
        kaz_pkg::RegLevelZero:  cfg_r.level_zero   <= pwdata[kaz_pkg::ValueW-1:0];
        kaz_pkg::RegStepSize:   cfg_r.step_size    <= pwdata[kaz_pkg::StepW-1:0];
        kaz_pkg::RegHoldTime:   cfg_r.hold_time_ms <= pwdata[kaz_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kaz_pkg::RegOffsetZero: prdata = {{16{cfg_r.offset_zero[15]}}, cfg_r.offset_zero};
      kaz_pkg::RegLevelZero:  prdata = {{16{cfg_r.level_zero[15]}}, cfg_r.level_zero};
      kaz_pkg::RegStepSize:   prdata = {22'd0, cfg_r.step_size};
      kaz_pkg::RegHoldTime:   prdata = {16'd0, cfg_r.hold_time_ms};
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== src/kaz_core.sv =====
module kaz_core (
  input  logic          clk,
  input  logic          rst_n,
  input  kaz_pkg::cfg_t cfg,
  kaz_in_if.sink        in_ch,
  kaz_out_if.source     out_ch
);

  // input stage
  logic                              s1_v_r;
  logic [kaz_pkg::KnobW-1:0]         knob_r;
  logic                              dir_r;
  logic [kaz_pkg::SlotW-1:0]         tsrc_r;
  logic signed [kaz_pkg::ValueW-1:0] cur_r;
  logic [kaz_pkg::TimeW-1:0]         now_r;

  // result stage
  logic                              out_v_r;
  logic                              apply_r;
  logic signed [kaz_pkg::ValueW-1:0] value_r;
  logic [kaz_pkg::SlotW-1:0]         slot_r;

  logic [kaz_pkg::TimeW-1:0] last_r [kaz_pkg::NumTimer];
  logic [kaz_pkg::TimeW-1:0] hold_r [kaz_pkg::NumSlot];

  logic                              advance;
  logic                              take;
  logic                              ignore;
  logic                              is_trig;
  logic [kaz_pkg::SlotW-1:0]         slot;
  logic [1:0]                        slot_idx;
  logic [2:0]                        tmr_idx;
  logic signed [kaz_pkg::ValueW-1:0] zero;
  logic [kaz_pkg::TimeW-1:0]         delta;
  logic [kaz_pkg::MultW-1:0]         mult;
  logic [kaz_pkg::ProdW-1:0]         step;
  logic signed [kaz_pkg::SumW-1:0]   cur_x;
  logic signed [kaz_pkg::SumW-1:0]   zero_x;
  logic signed [kaz_pkg::SumW-1:0]   step_x;
  logic signed [kaz_pkg::SumW-1:0]   sum;
  logic signed [kaz_pkg::SumW-1:0]   snapped;
  logic signed [kaz_pkg::ValueW-1:0] wrapped;
  logic                              at_zero;
  logic [kaz_pkg::TimeW-1:0]         hs;
  logic [kaz_pkg::TimeW-1:0]         hold_el;
  logic                              hold_on;
  logic                              expired;
  logic                              apply_nxt;
  logic signed [kaz_pkg::ValueW-1:0] value_nxt;
  logic [kaz_pkg::SlotW-1:0]         slot_nxt;

  assign advance      = !out_v_r || out_ch.ready;
  assign take         = s1_v_r && advance;
  assign in_ch.ready  = !s1_v_r || advance;

  assign out_ch.valid     = out_v_r;
  assign out_ch.apply     = apply_r;
  assign out_ch.new_value = value_r;
  assign out_ch.slot      = slot_r;

  always_comb begin
    ignore   = (knob_r == kaz_pkg::KnobUnused) ||
               ((knob_r == kaz_pkg::KnobTrig) && (tsrc_r == kaz_pkg::SlotBad));
    is_trig  = knob_r == kaz_pkg::KnobTrig;
    slot     = is_trig ? tsrc_r : knob_r;
    slot_idx = ignore ? 2'd0 : slot;
    tmr_idx  = ignore ? 3'd0 : {knob_r, dir_r};
    zero     = is_trig ? cfg.level_zero : cfg.offset_zero;

    // acceleration from time since this timer's previous step
    delta = now_r - last_r[tmr_idx];
    if (delta > kaz_pkg::ThreshSlow) begin
      mult = 3'd1;
    end else if (delta > kaz_pkg::ThreshMid) begin
      mult = 3'd2;
    end else if (delta > kaz_pkg::ThreshFast) begin
      mult = 3'd3;
    end else begin
      mult = 3'd4;
    end
    step = kaz_pkg::ProdW'(cfg.step_size * mult);

    cur_x  = kaz_pkg::SumW'(cur_r);
    zero_x = kaz_pkg::SumW'(zero);
    step_x = signed'({{(kaz_pkg::SumW-kaz_pkg::ProdW){1'b0}}, step});
    sum    = dir_r ? cur_x + step_x : cur_x - step_x;

    // snap to zero point when the move crosses it
    if ((cur_x > zero_x && sum < zero_x) || (cur_x < zero_x && sum > zero_x)) begin
      snapped = zero_x;
    end else begin
      snapped = sum;
    end
    wrapped = snapped[kaz_pkg::ValueW-1:0];
    at_zero = wrapped == zero;

    hs      = hold_r[slot_idx];
    hold_el = now_r - hs;
    hold_on = hs != '0;
    expired = hold_el > {{(kaz_pkg::TimeW-kaz_pkg::HoldW){1'b0}}, cfg.hold_time_ms};

    if (ignore) begin
      apply_nxt = 1'b0;
      value_nxt = cur_r;
      slot_nxt  = (knob_r == kaz_pkg::KnobUnused) ? '0 : kaz_pkg::SlotBad;
    end else begin
      apply_nxt = at_zero || !hold_on || expired;
      value_nxt = wrapped;
      slot_nxt  = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < kaz_pkg::NumTimer; i++) begin
        last_r[i] <= '0;
      end
      for (int i = 0; i < kaz_pkg::NumSlot; i++) begin
        hold_r[i] <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
      if (take && !ignore) begin
        last_r[tmr_idx] <= now_r;
        if (at_zero) begin
          hold_r[slot_idx] <= now_r;
        end else if (hold_on && expired) begin
          hold_r[slot_idx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      knob_r <= in_ch.knob;
      dir_r  <= in_ch.direction;
      tsrc_r <= in_ch.trigger_source;
      cur_r  <= in_ch.current_value;
      now_r  <= in_ch.now_ms;
    end
    if (take) begin
      apply_r <= apply_nxt;
      value_r <= value_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

// ===== src/knob_accel_zero_detent.sv =====
// a request passes from accept to result valid through the input register, then the result register
// throughput: one request per cycle while results are taken; single-pass logic between the two registers
// a stalled result lets one more request into the input register, after which
// input ready stays low until the result is taken
// reset (synchronous, rst_n low): event timers and zero holds cleared, registers to defaults
module knob_accel_zero_detent (
  input  logic                      clk,
  input  logic                      rst_n,
  kaz_in_if.sink                    in_ch,
  kaz_out_if.source                 out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [kaz_pkg::AddrW-1:0] cfg_paddr,
  input  logic [kaz_pkg::DataW-1:0] cfg_pwdata,
  output logic [kaz_pkg::DataW-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  kaz_pkg::cfg_t cfg;

  kaz_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  kaz_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_bad_slot_no_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.slot == kaz_pkg::SlotBad |-> !out_ch.apply)
    else $error("apply set on ignored trigger source");

endmodule
